// ===== rtl/v2n_pkg.sv =====
package v2n_pkg;

  localparam int unsigned CoordWidth   = 16;
  localparam int unsigned UnitFracBits = 14;
  localparam int unsigned UnitWidth    = UnitFracBits + 2;
  // Sum of two squares of magnitudes up to 2^15 can reach 2^31 and needs 32 bits.
  localparam int unsigned SumWidth     = 2 * CoordWidth;
  localparam int unsigned RootWidth    = CoordWidth;
  // Rounded root can reach 46341, which still fits in CoordWidth bits.
  localparam int unsigned NumWidth     = CoordWidth + UnitFracBits + 1;
  localparam int unsigned QuoWidth     = UnitFracBits + 2;

  typedef logic [CoordWidth-1:0] mag_t;
  typedef logic [UnitWidth-1:0]  unit_t;

endpackage

// ===== rtl/v2n_sqrt.sv =====
// Pipelined restoring square root: one result bit per stage, with rounding
// to nearest in a final stage. Side data rides along each stage.
module v2n_sqrt (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [v2n_pkg::SumWidth-1:0]  sum_i,
  input  logic [2*v2n_pkg::CoordWidth+1:0] side_i,
  output logic                          valid_o,
  output logic [v2n_pkg::RootWidth-1:0] root_o,
  output logic [2*v2n_pkg::CoordWidth+1:0] side_o
);
  import v2n_pkg::*;

  localparam int unsigned Steps = RootWidth;
  localparam int unsigned RemW  = RootWidth + 2;
  localparam int unsigned RadW  = 2 * RootWidth;
  localparam int unsigned SideW = 2 * CoordWidth + 2;

  logic [Steps:0]           vld_q;
  logic [RadW-1:0]          rad_q  [Steps+1];
  logic [RemW-1:0]          rem_q  [Steps+1];
  logic [RootWidth-1:0]     root_q [Steps+1];
  logic [SideW-1:0]         side_q [Steps+1];

  logic                     vld_out_q;
  logic [RootWidth-1:0]     rnd_q;
  logic [SideW-1:0]         side_out_q;

  always_comb begin
    vld_q[0]  = valid_i;
    rad_q[0]  = sum_i;
    rem_q[0]  = '0;
    root_q[0] = '0;
    side_q[0] = side_i;
  end

  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [RemW-1:0] trial;
    logic [RemW-1:0] rem_shift;
    always_comb begin
      rem_shift = {rem_q[s][RemW-3:0], rad_q[s][RadW-1 -: 2]};
      trial     = {root_q[s], 2'b01};
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      rad_q[s+1]  <= {rad_q[s][RadW-3:0], 2'b00};
      side_q[s+1] <= side_q[s];
      if (rem_shift >= trial) begin
        rem_q[s+1]  <= rem_shift - trial;
        root_q[s+1] <= {root_q[s][RootWidth-2:0], 1'b1};
      end else begin
        rem_q[s+1]  <= rem_shift;
        root_q[s+1] <= {root_q[s][RootWidth-2:0], 1'b0};
      end
    end
  end

  // Round up when the remainder exceeds the floor root.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    side_out_q <= side_q[Steps];
    if (rem_q[Steps] > {2'b00, root_q[Steps]}) begin
      rnd_q <= root_q[Steps] + RootWidth'(1);
    end else begin
      rnd_q <= root_q[Steps];
    end
  end

  assign valid_o = vld_out_q;
  assign root_o  = rnd_q;
  assign side_o  = side_out_q;
endmodule

// ===== rtl/v2n_div.sv =====
// Pipelined restoring divider for both components at once: one quotient bit
// per stage, then clamp and sign in a final stage.
module v2n_div (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           valid_i,
  input  logic [v2n_pkg::CoordWidth-1:0] len_i,
  input  logic [2*v2n_pkg::CoordWidth+1:0] side_i,
  output logic                           valid_o,
  output v2n_pkg::mag_t                  mag_o,
  output v2n_pkg::unit_t                 unit_x_o,
  output v2n_pkg::unit_t                 unit_y_o,
  output logic                           zero_o
);
  import v2n_pkg::*;

  // Quotient of (2c*2^F + L) / (2L); c <= 2^15, L >= c, so QuoWidth bits hold it.
  localparam int unsigned Steps = QuoWidth;
  localparam int unsigned DvsW  = CoordWidth + 1;
  localparam int unsigned SideW = 2 * CoordWidth + 2;

  logic [Steps:0]          vld_q;
  logic [CoordWidth-1:0]   len_q  [Steps+1];
  logic [SideW-1:0]        side_q [Steps+1];
  logic [NumWidth-1:0]     numx_q [Steps+1];
  logic [NumWidth-1:0]     numy_q [Steps+1];
  logic [DvsW:0]           remx_q [Steps+1];
  logic [DvsW:0]           remy_q [Steps+1];
  logic [QuoWidth-1:0]     qx_q   [Steps+1];
  logic [QuoWidth-1:0]     qy_q   [Steps+1];

  logic                    vld_out_q;
  mag_t                    mag_q;
  unit_t                   ux_q, uy_q;
  logic                    zero_q;

  logic [CoordWidth-1:0]   ax_in, ay_in;

  always_comb begin
    ax_in     = side_i[CoordWidth-1:0];
    ay_in     = side_i[2*CoordWidth-1:CoordWidth];
    vld_q[0]  = valid_i;
    len_q[0]  = len_i;
    side_q[0] = side_i;
    numx_q[0] = {ax_in, {(UnitFracBits+1){1'b0}}} + NumWidth'(len_i);
    numy_q[0] = {ay_in, {(UnitFracBits+1){1'b0}}} + NumWidth'(len_i);
    remx_q[0] = '0;
    remy_q[0] = '0;
    qx_q[0]   = '0;
    qy_q[0]   = '0;
  end

  // Remainders before stage Steps are known to be below 2L, so the numerator
  // bits above the quotient width feed the initial remainder directly.
  for (genvar s = 0; s < Steps; s++) begin : g_step
    logic [DvsW:0] shx, shy, dvs;
    always_comb begin
      dvs = {1'b0, len_q[s], 1'b0};
      if (s == 0) begin
        shx = (DvsW+1)'(numx_q[s] >> (Steps - 1));
        shy = (DvsW+1)'(numy_q[s] >> (Steps - 1));
      end else begin
        shx = {remx_q[s][DvsW-1:0], numx_q[s][Steps-1-s]};
        shy = {remy_q[s][DvsW-1:0], numy_q[s][Steps-1-s]};
      end
    end
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[s+1] <= 1'b0;
      end else begin
        vld_q[s+1] <= vld_q[s];
      end
    end
    always_ff @(posedge clk_i) begin
      len_q[s+1]  <= len_q[s];
      side_q[s+1] <= side_q[s];
      numx_q[s+1] <= numx_q[s];
      numy_q[s+1] <= numy_q[s];
      if (shx >= dvs) begin
        remx_q[s+1] <= shx - dvs;
        qx_q[s+1]   <= {qx_q[s][QuoWidth-2:0], 1'b1};
      end else begin
        remx_q[s+1] <= shx;
        qx_q[s+1]   <= {qx_q[s][QuoWidth-2:0], 1'b0};
      end
      if (shy >= dvs) begin
        remy_q[s+1] <= shy - dvs;
        qy_q[s+1]   <= {qy_q[s][QuoWidth-2:0], 1'b1};
      end else begin
        remy_q[s+1] <= shy;
        qy_q[s+1]   <= {qy_q[s][QuoWidth-2:0], 1'b0};
      end
    end
  end

  localparam logic [QuoWidth-1:0] One = QuoWidth'(1) << UnitFracBits;

  logic [QuoWidth-1:0] cx, cy;
  logic                nx, ny, zr;

  always_comb begin
    nx = side_q[Steps][2*CoordWidth];
    ny = side_q[Steps][2*CoordWidth+1];
    zr = (len_q[Steps] == '0);
    cx = (qx_q[Steps] > One) ? One : qx_q[Steps];
    cy = (qy_q[Steps] > One) ? One : qy_q[Steps];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_out_q <= 1'b0;
    end else begin
      vld_out_q <= vld_q[Steps];
    end
  end

  // A zero length can only come from a zero vector.
  always_ff @(posedge clk_i) begin
    mag_q  <= len_q[Steps];
    zero_q <= zr;
    ux_q   <= zr ? '0 : (nx ? UnitWidth'(-cx) : UnitWidth'(cx));
    uy_q   <= zr ? '0 : (ny ? UnitWidth'(-cy) : UnitWidth'(cy));
  end

  assign valid_o  = vld_out_q;
  assign mag_o    = mag_q;
  assign unit_x_o = ux_q;
  assign unit_y_o = uy_q;
  assign zero_o   = zero_q;
endmodule

// ===== rtl/vector2d_normalize.sv =====
// From start to done, an item passes the absolute-value and square registers,
// then the square-root pipeline (one bit per stage plus rounding) and then the
// divider pipeline (one quotient bit per stage plus clamp and sign).
// Throughput: one item per cycle; busy is always low and the receiver cannot stall.
// Reset clears all valid bits; no result is produced until items arrive.
module vector2d_normalize (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [v2n_pkg::CoordWidth-1:0] vec_x_i,
  input  logic [v2n_pkg::CoordWidth-1:0] vec_y_i,
  output logic                           done,
  output v2n_pkg::mag_t                  magnitude_o,
  output v2n_pkg::unit_t                 unit_x_o,
  output v2n_pkg::unit_t                 unit_y_o,
  output logic                           is_zero_o
);
  import v2n_pkg::*;

  localparam int unsigned SideW = 2 * CoordWidth + 2;

  logic                  v1_q, v2_q;
  logic [CoordWidth-1:0] ax_q, ay_q;
  logic                  nx_q, ny_q;
  logic [SumWidth-1:0]   sqx_q, sqy_q;
  logic [SideW-1:0]      side2_q;
  logic [CoordWidth-1:0] ax_d, ay_d;

  logic                  sv;
  logic [RootWidth-1:0]  root;
  logic [SideW-1:0]      sside;

  always_comb begin
    ax_d = vec_x_i[CoordWidth-1] ? CoordWidth'(-vec_x_i) : vec_x_i;
    ay_d = vec_y_i[CoordWidth-1] ? CoordWidth'(-vec_y_i) : vec_y_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= start;
      v2_q <= v1_q;
    end
  end

  // The negation of the most negative code wraps to 2^15 in an unsigned view.
  always_ff @(posedge clk_i) begin
    ax_q    <= ax_d;
    ay_q    <= ay_d;
    nx_q    <= vec_x_i[CoordWidth-1];
    ny_q    <= vec_y_i[CoordWidth-1];
    sqx_q   <= {{CoordWidth{1'b0}}, ax_q} * {{CoordWidth{1'b0}}, ax_q};
    sqy_q   <= {{CoordWidth{1'b0}}, ay_q} * {{CoordWidth{1'b0}}, ay_q};
    side2_q <= {ny_q, nx_q, ay_q, ax_q};
  end

  v2n_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (v2_q),
    .sum_i   (sqx_q + sqy_q),
    .side_i  (side2_q),
    .valid_o (sv),
    .root_o  (root),
    .side_o  (sside)
  );

  v2n_div u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sv),
    .len_i    (root),
    .side_i   (sside),
    .valid_o  (done),
    .mag_o    (magnitude_o),
    .unit_x_o (unit_x_o),
    .unit_y_o (unit_y_o),
    .zero_o   (is_zero_o)
  );

  assign busy = 1'b0;
endmodule

// ===== verif/tb_vector2d_normalize.sv =====
`timescale 1ns / 100ps

module tb_vector2d_normalize;
  import v2n_pkg::*;

  localparam int unsigned WatchdogLimit = 2000;
  localparam int unsigned LatencyCycles = 36;

  typedef struct packed {
    mag_t  magnitude;
    unit_t unit_x;
    unit_t unit_y;
    logic  is_zero;
  } norm_t;

  class norm_scoreboard;
    norm_t pending_q[$];
    int unsigned err_count;

    // Rounded square root of a sum of squares; an exact tie cannot occur.
    function automatic logic [31:0] round_root(logic [31:0] sum);
      logic [31:0] root;
      logic [63:0] sq;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        sq = (root | (32'd1 << b)) * (root | (32'd1 << b));
        if (sq <= sum) root = root | (32'd1 << b);
      end
      if (sum - root * root > root) root = root + 1;
      return root;
    endfunction

    function automatic unit_t unit_of(logic [31:0] abs_c, logic neg, logic [31:0] len);
      logic [63:0] q;
      q = ((64'(abs_c) << (UnitFracBits + 1)) + len) / (64'(len) << 1);
      if (q > (64'd1 << UnitFracBits)) q = 64'd1 << UnitFracBits;
      if (neg) q = -q;
      return unit_t'(q);
    endfunction

    function void note_vector(logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] y);
      norm_t e;
      logic [31:0] ax, ay, sum, len;
      ax = x[CoordWidth-1] ? 32'((17'd1 << CoordWidth) - x) : 32'(x);
      ay = y[CoordWidth-1] ? 32'((17'd1 << CoordWidth) - y) : 32'(y);
      sum = ax * ax + ay * ay;
      if (sum == 0) begin
        e = '{magnitude: '0, unit_x: '0, unit_y: '0, is_zero: 1'b1};
      end else begin
        len = round_root(sum);
        e.magnitude = mag_t'(len);
        e.unit_x = unit_of(ax, x[CoordWidth-1], len);
        e.unit_y = unit_of(ay, y[CoordWidth-1], len);
        e.is_zero = 1'b0;
      end
      pending_q.push_back(e);
    endfunction

    function void check_result(norm_t got);
      norm_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, got);
        err_count++;
        return;
      end
      e = pending_q.pop_front();
      if (got.magnitude !== e.magnitude) begin
        $display("%0t: magnitude expected %0d actual %0d", $time, e.magnitude, got.magnitude);
        err_count++;
      end
      if (got.unit_x !== e.unit_x) begin
        $display("%0t: unit_x expected %0d actual %0d", $time, $signed(e.unit_x),
                 $signed(got.unit_x));
        err_count++;
      end
      if (got.unit_y !== e.unit_y) begin
        $display("%0t: unit_y expected %0d actual %0d", $time, $signed(e.unit_y),
                 $signed(got.unit_y));
        err_count++;
      end
      if (got.is_zero !== e.is_zero) begin
        $display("%0t: is_zero expected %0b actual %0b", $time, e.is_zero, got.is_zero);
        err_count++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [CoordWidth-1:0] vec_x_i = '0;
  logic [CoordWidth-1:0] vec_y_i = '0;
  logic done;
  mag_t magnitude_o;
  unit_t unit_x_o, unit_y_o;
  logic is_zero_o;

  norm_scoreboard board = new();
  int unsigned quiet_cycles = 0;
  bit allow_gaps = 1'b1;

  vector2d_normalize uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .vec_x_i(vec_x_i), .vec_y_i(vec_y_i), .done(done),
    .magnitude_o(magnitude_o), .unit_x_o(unit_x_o), .unit_y_o(unit_y_o),
    .is_zero_o(is_zero_o)
  );

  always #4 clk_i = ~clk_i;

  // Both handshakes are sampled at the edge; drivers update after it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy) board.note_vector(vec_x_i, vec_y_i);
      if (done) board.check_result('{magnitude_o, unit_x_o, unit_y_o, is_zero_o});
      if ((start && !busy) || done) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Holds one vector on the ports until it is accepted, with an optional gap first.
  task automatic send_vector(logic [CoordWidth-1:0] x, logic [CoordWidth-1:0] y);
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    start <= 1'b1;
    vec_x_i <= x;
    vec_y_i <= y;
    do @(posedge clk_i); while (busy);
  endtask

  function automatic logic [CoordWidth-1:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return CoordWidth'($urandom_range(0, 8) - 4);
      1: return $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
      2: return CoordWidth'($urandom_range(0, 511) - 256);
      default: return CoordWidth'($urandom);
    endcase
  endfunction

  initial begin
    logic [CoordWidth-1:0] edge_vals[8];
    edge_vals = '{16'h0000, 16'h0001, 16'hffff, 16'h7fff, 16'h8000, 16'h0100,
                  16'hff00, 16'h5555};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // Directed pairs: zero vector, axes, extremes, and corners that stress the clamp.
    for (int i = 0; i < 5; i++)
      for (int j = 0; j < 5; j++) send_vector(edge_vals[i], edge_vals[j]);
    send_vector(16'h0001, 16'h0001);
    send_vector(16'h0003, 16'h0004);
    start <= 1'b0;
    // Sender waits until every expected result is back.
    while (board.pending_q.size() != 0) @(posedge clk_i);
    for (int n = 0; n < 800; n++) begin
      if (n == 650) allow_gaps = 1'b0;
      send_vector(rand_coord(), rand_coord());
    end
    start <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk_i);
    repeat (LatencyCycles + 4) @(posedge clk_i);
    if (board.err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
